/* src/mpth_pkg.sv */
package mpth_pkg;

  // field widths of the candidate and result items
  localparam int PT_W    = 16;
  localparam int ETA_W   = 12;
  localparam int STRAT_W = 4;
  localparam int CHI2_W  = 16;
  localparam int THR_W   = 16;
  localparam int CUT_W   = 16;

  // magnitudes need one more bit than the signed value
  localparam int APT_W  = PT_W + 1;
  localparam int AETA_W = ETA_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int MODE_W     = 3;

  // defaults of the top level parameters
  localparam int NUM_BINS_DEF       = 4;
  localparam int NUM_STRATEGIES_DEF = 4;
  localparam int NUM_CUT_SETS_DEF   = 2;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_EDGES0     = 3'd1,
    REG_THRESH0    = 3'd2,
    REG_EDGES1     = 3'd3,
    REG_THRESH1    = 3'd4,
    REG_STRAT_CUTS = 3'd5,
    REG_PIK_MAX_PT = 3'd6,
    REG_CHI2_MAX   = 3'd7
  } reg_idx_t;

  // mode register bits
  typedef struct packed {
    logic strat_en;
    logic pik_en;
    logic accept_all;
  } mode_t;

  // one candidate
  typedef struct packed {
    logic                      cut_set;
    logic signed [PT_W-1:0]    pt_signed;
    logic signed [ETA_W-1:0]   eta_value;
    logic [STRAT_W-1:0]        strategy_code;
    logic [CHI2_W-1:0]         track_chi2;
    logic                      has_candidate;
    logic                      has_standalone;
    logic                      has_id_track;
  } item_t;

  // one decision
  typedef struct packed {
    logic passed;
    logic std_cut_ok;
    logic pik_cut_ok;
    logic strategy_cut_ok;
  } res_t;

endpackage

/* src/mpth_if.sv */
// candidate channel
interface mpth_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cut_set;
  logic signed [mpth_pkg::PT_W-1:0]      pt_signed;
  logic signed [mpth_pkg::ETA_W-1:0]     eta_value;
  logic [mpth_pkg::STRAT_W-1:0]          strategy_code;
  logic [mpth_pkg::CHI2_W-1:0]           track_chi2;
  logic                                  has_candidate;
  logic                                  has_standalone;
  logic                                  has_id_track;

  modport source (
    output valid, cut_set, pt_signed, eta_value, strategy_code, track_chi2,
           has_candidate, has_standalone, has_id_track,
    input  ready
  );
  modport sink (
    input  valid, cut_set, pt_signed, eta_value, strategy_code, track_chi2,
           has_candidate, has_standalone, has_id_track,
    output ready
  );
endinterface

// decision channel
interface mpth_out_if;
  logic valid;
  logic ready;
  logic passed;
  logic std_cut_ok;
  logic pik_cut_ok;
  logic strategy_cut_ok;

  modport source (
    output valid, passed, std_cut_ok, pik_cut_ok, strategy_cut_ok,
    input  ready
  );
  modport sink (
    input  valid, passed, std_cut_ok, pik_cut_ok, strategy_cut_ok,
    output ready
  );
endinterface

// register write channel
interface mpth_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mpth_pkg::CFG_IDX_W-1:0]    index;
  logic [mpth_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/muon_pt_hypothesis_cut_top.sv */
// path: an accepted candidate passes the input register, then the decision register
// throughput: 1 candidate per cycle unless out_ch stalls, set by the input register
//   feeding the compare logic and decision register, each moving as the next frees
// reset: rst_n synchronous active low, clears both pipeline valids and all
//   configuration registers to zero
module muon_pt_hypothesis_cut_top #(
  parameter int NUM_BINS       = mpth_pkg::NUM_BINS_DEF,
  parameter int NUM_STRATEGIES = mpth_pkg::NUM_STRATEGIES_DEF,
  parameter int NUM_CUT_SETS   = mpth_pkg::NUM_CUT_SETS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mpth_in_if.sink      in_ch,
  mpth_out_if.source   out_ch,
  mpth_cfg_if.sink     cfg_ch
);

  mpth_pkg::mode_t                                          mode;
  logic [NUM_CUT_SETS-1:0][NUM_BINS:0][mpth_pkg::ETA_W-1:0]   edges;
  logic [NUM_CUT_SETS-1:0][NUM_BINS-1:0][mpth_pkg::THR_W-1:0] thresholds;
  logic [NUM_STRATEGIES-1:0][mpth_pkg::CUT_W-1:0]           strat_cuts;
  logic [mpth_pkg::PT_W-1:0]                                pik_max_pt;
  logic [mpth_pkg::CHI2_W-1:0]                              chi2_max;

  mpth_pkg::item_t in_item;
  mpth_pkg::item_t item_r;
  logic            item_vld_r, item_vld_nxt;
  mpth_pkg::res_t  res;
  mpth_pkg::res_t  res_r;
  logic            res_vld_r, res_vld_nxt;
  logic            res_take;
  logic            item_take;
  logic            in_take;

  // configuration registers
  mpth_cfg_regs #(
    .NUM_BINS       (NUM_BINS),
    .NUM_STRATEGIES (NUM_STRATEGIES),
    .NUM_CUT_SETS   (NUM_CUT_SETS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .mode       (mode),
    .edges      (edges),
    .thresholds (thresholds),
    .strat_cuts (strat_cuts),
    .pik_max_pt (pik_max_pt),
    .chi2_max   (chi2_max)
  );

  // pack the incoming candidate
  assign in_item = '{
    cut_set:        in_ch.cut_set,
    pt_signed:      in_ch.pt_signed,
    eta_value:      in_ch.eta_value,
    strategy_code:  in_ch.strategy_code,
    track_chi2:     in_ch.track_chi2,
    has_candidate:  in_ch.has_candidate,
    has_standalone: in_ch.has_standalone,
    has_id_track:   in_ch.has_id_track
  };

  // pipeline flow control, each stage moves when the next one frees up
  assign res_take    = !res_vld_r || out_ch.ready;
  assign item_take   = !item_vld_r || res_take;
  assign in_ch.ready = item_take;
  assign in_take     = in_ch.valid && item_take;

  assign item_vld_nxt = item_take ? in_ch.valid : item_vld_r;
  assign res_vld_nxt  = res_take ? item_vld_r : res_vld_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_item;
    end
    if (res_take && item_vld_r) begin
      res_r <= res;
    end
  end

  // cut evaluation between the two registers
  mpth_eval #(
    .NUM_BINS       (NUM_BINS),
    .NUM_STRATEGIES (NUM_STRATEGIES),
    .NUM_CUT_SETS   (NUM_CUT_SETS)
  ) u_eval (
    .item       (item_r),
    .mode       (mode),
    .edges      (edges),
    .thresholds (thresholds),
    .strat_cuts (strat_cuts),
    .pik_max_pt (pik_max_pt),
    .chi2_max   (chi2_max),
    .res        (res)
  );

  assign out_ch.valid           = res_vld_r;
  assign out_ch.passed          = res_r.passed;
  assign out_ch.std_cut_ok      = res_r.std_cut_ok;
  assign out_ch.pik_cut_ok      = res_r.pik_cut_ok;
  assign out_ch.strategy_cut_ok = res_r.strategy_cut_ok;

  // decision is always the and of the three partial flags
  a_pass_is_and: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.passed ==
      (out_ch.std_cut_ok && out_ch.pik_cut_ok && out_ch.strategy_cut_ok)))
    else $error("passed disagrees with partial flags");

  // a staged candidate moving forward shows up as a decision next cycle
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && res_take) |=> out_ch.valid)
    else $error("staged candidate lost");

  // both stages full and output stalled means no new transaction
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && res_vld_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("candidate accepted into a full pipeline");

  // no decision right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_ch.valid && !item_vld_r))
    else $error("pipeline not empty after reset");

endmodule

/* src/mpth_cfg_regs.sv */
module mpth_cfg_regs #(
  parameter int NUM_BINS       = mpth_pkg::NUM_BINS_DEF,
  parameter int NUM_STRATEGIES = mpth_pkg::NUM_STRATEGIES_DEF,
  parameter int NUM_CUT_SETS   = mpth_pkg::NUM_CUT_SETS_DEF
) (
  input  logic                                                     clk,
  input  logic                                                     rst_n,
  mpth_cfg_if.sink                                                 cfg_ch,
  output mpth_pkg::mode_t                                          mode,
  output logic [NUM_CUT_SETS-1:0][NUM_BINS:0][mpth_pkg::ETA_W-1:0]  edges,
  output logic [NUM_CUT_SETS-1:0][NUM_BINS-1:0][mpth_pkg::THR_W-1:0] thresholds,
  output logic [NUM_STRATEGIES-1:0][mpth_pkg::CUT_W-1:0]           strat_cuts,
  output logic [mpth_pkg::PT_W-1:0]                                pik_max_pt,
  output logic [mpth_pkg::CHI2_W-1:0]                              chi2_max
);

  localparam int EDGE_W  = (NUM_BINS + 1) * mpth_pkg::ETA_W;
  localparam int THR_TW  = NUM_BINS * mpth_pkg::THR_W;
  localparam int CUTS_TW = NUM_STRATEGIES * mpth_pkg::CUT_W;

  mpth_pkg::mode_t                                          mode_r, mode_nxt;
  logic [NUM_CUT_SETS-1:0][NUM_BINS:0][mpth_pkg::ETA_W-1:0]   edges_r, edges_nxt;
  logic [NUM_CUT_SETS-1:0][NUM_BINS-1:0][mpth_pkg::THR_W-1:0] thr_r, thr_nxt;
  logic [NUM_STRATEGIES-1:0][mpth_pkg::CUT_W-1:0]           cuts_r, cuts_nxt;
  logic [mpth_pkg::PT_W-1:0]                                pik_r, pik_nxt;
  logic [mpth_pkg::CHI2_W-1:0]                              chi2_r, chi2_nxt;
  logic                                                     wr_en;

  // registers take a write in any cycle
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;

  // register write decode
  always_comb begin
    mode_nxt  = mode_r;
    edges_nxt = edges_r;
    thr_nxt   = thr_r;
    cuts_nxt  = cuts_r;
    pik_nxt   = pik_r;
    chi2_nxt  = chi2_r;
    if (wr_en) begin
      case (mpth_pkg::reg_idx_t'(cfg_ch.index))
        mpth_pkg::REG_MODE: begin
          mode_nxt = mpth_pkg::mode_t'(cfg_ch.data[mpth_pkg::MODE_W-1:0]);
        end
        mpth_pkg::REG_EDGES0: begin
          edges_nxt[0] = cfg_ch.data[EDGE_W-1:0];
        end
        mpth_pkg::REG_THRESH0: begin
          thr_nxt[0] = cfg_ch.data[THR_TW-1:0];
        end
        mpth_pkg::REG_EDGES1: begin
          if (NUM_CUT_SETS > 1) begin
            edges_nxt[NUM_CUT_SETS-1] = cfg_ch.data[EDGE_W-1:0];
          end
        end
        mpth_pkg::REG_THRESH1: begin
          if (NUM_CUT_SETS > 1) begin
            thr_nxt[NUM_CUT_SETS-1] = cfg_ch.data[THR_TW-1:0];
          end
        end
        mpth_pkg::REG_STRAT_CUTS: begin
          cuts_nxt = cfg_ch.data[CUTS_TW-1:0];
        end
        mpth_pkg::REG_PIK_MAX_PT: begin
          pik_nxt = cfg_ch.data[mpth_pkg::PT_W-1:0];
        end
        mpth_pkg::REG_CHI2_MAX: begin
          chi2_nxt = cfg_ch.data[mpth_pkg::CHI2_W-1:0];
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // register storage, all cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      edges_r <= '0;
      thr_r   <= '0;
      cuts_r  <= '0;
      pik_r   <= '0;
      chi2_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      edges_r <= edges_nxt;
      thr_r   <= thr_nxt;
      cuts_r  <= cuts_nxt;
      pik_r   <= pik_nxt;
      chi2_r  <= chi2_nxt;
    end
  end

  assign mode       = mode_r;
  assign edges      = edges_r;
  assign thresholds = thr_r;
  assign strat_cuts = cuts_r;
  assign pik_max_pt = pik_r;
  assign chi2_max   = chi2_r;

endmodule

/* src/mpth_eval.sv */
module mpth_eval #(
  parameter int NUM_BINS       = mpth_pkg::NUM_BINS_DEF,
  parameter int NUM_STRATEGIES = mpth_pkg::NUM_STRATEGIES_DEF,
  parameter int NUM_CUT_SETS   = mpth_pkg::NUM_CUT_SETS_DEF
) (
  input  mpth_pkg::item_t                                          item,
  input  mpth_pkg::mode_t                                          mode,
  input  logic [NUM_CUT_SETS-1:0][NUM_BINS:0][mpth_pkg::ETA_W-1:0]  edges,
  input  logic [NUM_CUT_SETS-1:0][NUM_BINS-1:0][mpth_pkg::THR_W-1:0] thresholds,
  input  logic [NUM_STRATEGIES-1:0][mpth_pkg::CUT_W-1:0]           strat_cuts,
  input  logic [mpth_pkg::PT_W-1:0]                                pik_max_pt,
  input  logic [mpth_pkg::CHI2_W-1:0]                              chi2_max,
  output mpth_pkg::res_t                                           res
);

  logic [NUM_BINS:0][mpth_pkg::ETA_W-1:0]   edge_sel;
  logic [NUM_BINS-1:0][mpth_pkg::THR_W-1:0] thr_row;
  logic                                     use_last_set;
  logic [mpth_pkg::APT_W-1:0]               pt_ext, apt;
  logic [mpth_pkg::ETA_W:0]                 eta_ext, eta_mag;
  logic [mpth_pkg::AETA_W-1:0]              aeta;
  logic [mpth_pkg::THR_W-1:0]               thr;
  logic [mpth_pkg::CUT_W-1:0]               cut;
  logic [mpth_pkg::APT_W-1:0]               cut_ext, acut;
  logic                                     strat_hit;
  logic                                     reject;
  logic                                     std_ok, pik_ok, sdp_ok;

  // cut set select, indexes past the last set fall back to it
  assign use_last_set = (NUM_CUT_SETS > 1) && item.cut_set;
  assign edge_sel     = use_last_set ? edges[NUM_CUT_SETS-1] : edges[0];
  assign thr_row      = use_last_set ? thresholds[NUM_CUT_SETS-1] : thresholds[0];

  // magnitudes of pt and eta
  assign pt_ext  = {item.pt_signed[mpth_pkg::PT_W-1], item.pt_signed};
  assign apt     = item.pt_signed[mpth_pkg::PT_W-1] ? (~pt_ext + 1'b1) : pt_ext;
  assign eta_ext = {item.eta_value[mpth_pkg::ETA_W-1], item.eta_value};
  assign eta_mag = item.eta_value[mpth_pkg::ETA_W-1] ? (~eta_ext + 1'b1) : eta_ext;
  assign aeta    = eta_mag[mpth_pkg::AETA_W-1:0];

  // eta bin lookup, strict edges, last matching bin wins
  always_comb begin
    thr = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      if ((aeta > {1'b0, edge_sel[i]}) && (aeta < {1'b0, edge_sel[i+1]})) begin
        thr = thr_row[i];
      end
    end
  end

  // strategy cut select
  always_comb begin
    cut       = '0;
    strat_hit = 1'b0;
    for (int s = 0; s < NUM_STRATEGIES; s++) begin
      if (item.strategy_code == mpth_pkg::STRAT_W'(s + 1)) begin
        cut       = strat_cuts[s];
        strat_hit = 1'b1;
      end
    end
  end

  assign cut_ext = {cut[mpth_pkg::CUT_W-1], cut};
  assign acut    = cut[mpth_pkg::CUT_W-1] ? (~cut_ext + 1'b1) : cut_ext;

  // partial cuts
  always_comb begin
    pik_ok = 1'b1;
    if (mode.pik_en && (apt < {1'b0, pik_max_pt}) && (item.track_chi2 > chi2_max)) begin
      pik_ok = 1'b0;
    end
    std_ok = apt > {1'b0, thr};
    sdp_ok = 1'b1;
    if (mode.strat_en && strat_hit) begin
      if (apt <= acut) begin
        sdp_ok = 1'b0;
      end
      // negative strategy cut turns the standard cut off
      if (cut[mpth_pkg::CUT_W-1]) begin
        std_ok = 1'b1;
      end
    end
  end

  assign reject = !item.has_candidate || (item.pt_signed == '0) ||
                  !item.has_standalone || !item.has_id_track;

  // final decision with accept-all and reject overrides
  always_comb begin
    if (mode.accept_all) begin
      res = '{passed: 1'b1, std_cut_ok: 1'b1, pik_cut_ok: 1'b1, strategy_cut_ok: 1'b1};
    end else if (reject) begin
      res = '0;
    end else begin
      res.passed          = std_ok && pik_ok && sdp_ok;
      res.std_cut_ok      = std_ok;
      res.pik_cut_ok      = pik_ok;
      res.strategy_cut_ok = sdp_ok;
    end
  end

endmodule
